/* rtl/gtsa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gtsa_pkg;

  // default tile geometry
  localparam int TileRowsDef = 16;
  localparam int TileColsDef = 16;
  localparam int MaxDepthDef = 64;

  // request kinds carried in tuser
  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // configuration register indexes
  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_BETA  = 2'd1;
  localparam logic [1:0] REG_DEPTH = 2'd2;

  localparam logic [31:0] ALPHA_RST = 32'h0001_0000;
  localparam logic [31:0] BETA_RST  = 32'h0000_0000;
  localparam logic [6:0]  DEPTH_RST = 7'd64;

  localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_LO = -64'sh0000_0000_8000_0000;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MAC   = 6'b000010,
    S_SAT   = 6'b000100,
    S_ALPHA = 6'b001000,
    S_BETA  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_LO) begin
      r = -32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/gemm_tile_scaled_accumulate_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel      Direction  Handshake                   Payload
// s_axis       in         s_axis_tvalid/tready        tdata {value,depth,col,row}, tuser op
// m_axis       out        m_axis_tvalid/tready        tdata {col,row,out_value}
// apb          in         psel/penable/pready         alpha_scale, beta_scale, depth_count
//
// Load requests are taken back to back; no request is taken while a finish runs. A
// finish request runs n multiply-accumulates, n being depth_count capped at MAX_DEPTH, one a
// cycle through the single 32x32 multiplier, then the same multiplier forms alpha*sum and beta*c.
// Reset clears control and configuration; tile stores hold garbage until loaded.
// A result held in the output register stalls only the final step of the next finish.
module gemm_tile_scaled_accumulate_core #(
  parameter int TILE_ROWS = gtsa_pkg::TileRowsDef,
  parameter int TILE_COLS = gtsa_pkg::TileColsDef,
  parameter int MAX_DEPTH = gtsa_pkg::MaxDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [3:0] row_index, [7:4] col_index, [13:8] depth_index, [45:14] value, [47:46] zero
  input  wire logic [47:0] s_axis_tdata,
  // [1:0] op
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] out_value, [35:32] out_row, [39:36] out_col
  output logic [39:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import gtsa_pkg::*;

  localparam int ADEPTH = TILE_ROWS * MAX_DEPTH;
  localparam int BDEPTH = MAX_DEPTH * TILE_COLS;
  localparam int AAW = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
  localparam int BAW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int DCW = $clog2(MAX_DEPTH + 1);

  logic [31:0] a_mem [ADEPTH];
  logic [31:0] b_mem [BDEPTH];

  logic [3:0]         in_row, in_col;
  logic [5:0]         in_dep;
  logic [31:0]        in_val;
  op_e                in_op;
  logic               s_acc;

  logic signed [31:0] alpha_q, beta_q;
  logic [6:0]         depth_q;
  logic               cfg_wr;

  state_e             state_q, state_d;
  logic [3:0]         row_q, col_q;
  logic signed [31:0] c_q;
  logic [DCW-1:0]     n_q, cnt_q;
  logic               rd_v_q, mv_q;
  logic signed [31:0] a_rd_q, b_rd_q;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_q;
  logic signed [63:0] acc_q;
  logic signed [31:0] sum_q;
  logic signed [47:0] t1_q;
  logic signed [63:0] total;
  logic               issue;
  logic               out_free;
  logic [AAW-1:0]     a_waddr, a_raddr;
  logic [BAW-1:0]     b_waddr, b_raddr;
  logic [DCW-1:0]     n_eff;
  logic               a_wr_ok, b_wr_ok, fin_ok;

  assign in_row = s_axis_tdata[3:0];
  assign in_col = s_axis_tdata[7:4];
  assign in_dep = s_axis_tdata[13:8];
  assign in_val = s_axis_tdata[45:14];
  assign in_op  = op_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RST;
      beta_q  <= BETA_RST;
      depth_q <= DEPTH_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ALPHA: alpha_q <= pwdata;
        REG_BETA:  beta_q  <= pwdata;
        REG_DEPTH: depth_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ALPHA: prdata = alpha_q;
      REG_BETA:  prdata = beta_q;
      REG_DEPTH: prdata = {25'd0, depth_q};
      default:   prdata = 32'd0;
    endcase
  end

  // tile stores
  assign a_wr_ok = (int'(in_row) < TILE_ROWS) && (int'(in_dep) < MAX_DEPTH);
  assign b_wr_ok = (int'(in_col) < TILE_COLS) && (int'(in_dep) < MAX_DEPTH);
  assign fin_ok  = (int'(in_row) < TILE_ROWS) && (int'(in_col) < TILE_COLS);
  assign a_waddr = AAW'(int'(in_row) * MAX_DEPTH + int'(in_dep));
  assign b_waddr = BAW'(int'(in_dep) * TILE_COLS + int'(in_col));
  assign a_raddr = AAW'(int'(row_q) * MAX_DEPTH + int'(cnt_q));
  assign b_raddr = BAW'(int'(cnt_q) * TILE_COLS + int'(col_q));

  always_ff @(posedge clk_i) begin
    if (s_acc && in_op == OP_LOAD_A && a_wr_ok) begin
      a_mem[a_waddr] <= in_val;
    end
    a_rd_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && in_op == OP_LOAD_B && b_wr_ok) begin
      b_mem[b_waddr] <= in_val;
    end
    b_rd_q <= b_mem[b_raddr];
  end

  // cap the depth at the store size
  assign n_eff = (int'(depth_q) > MAX_DEPTH) ? DCW'(MAX_DEPTH) : DCW'(depth_q);

  assign issue    = (state_q == S_MAC) && (cnt_q != n_q);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_acc && in_op == OP_FINISH && fin_ok) begin
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        if (!issue && !rd_v_q && !mv_q) begin
          state_d = S_SAT;
        end
      end
      S_SAT:   state_d = S_ALPHA;
      S_ALPHA: state_d = S_BETA;
      S_BETA:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rd_v_q  <= 1'b0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= issue;
      mv_q    <= rd_v_q;
      if (state_q == S_IDLE) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // latch each accepted request; a finish's fields are held while it runs
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      row_q <= in_row;
      col_q <= in_col;
      c_q   <= in_val;
      n_q   <= n_eff;
    end
  end

  // shared multiplier: products first, then alpha*sum, then beta*c
  always_comb begin
    case (state_q)
      S_ALPHA: begin
        mul_a = alpha_q;
        mul_b = sum_q;
      end
      S_BETA: begin
        mul_a = beta_q;
        mul_b = c_q;
      end
      default: begin
        mul_a = a_rd_q;
        mul_b = b_rd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MAC || state_q == S_ALPHA || state_q == S_BETA) begin
      mul_q <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      acc_q <= '0;
    end else if (mv_q) begin
      acc_q <= acc_q + (mul_q >>> 16);
    end
    if (state_q == S_SAT) begin
      sum_q <= sat32(acc_q);
    end
    if (state_q == S_BETA) begin
      t1_q <= mul_q[63:16];
    end
  end

  assign total = 64'(t1_q) + (mul_q >>> 16);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      m_axis_tdata <= {col_q, row_q, sat32(total)};
    end
  end

endmodule

`default_nettype wire

/* bench/tb_gemm_tile_scaled_accumulate_core.sv */
`timescale 1ns / 1ps

module tb_gemm_tile_scaled_accumulate_core;
  import gtsa_pkg::*;

  typedef struct packed {
    op_e         op;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [5:0]  depth;
    logic [31:0] value;
  } tile_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic [3:0]  row;
    logic [3:0]  col;
  } c_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [3:0] row_index, [7:4] col_index, [13:8] depth_index, [45:14] value, [47:46] zero
  logic [47:0] s_axis_tdata = '0;
  // [1:0] op
  logic [1:0]  s_axis_tuser = OP_NONE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [31:0] out_value, [35:32] out_row, [39:36] out_col
  logic [39:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  gemm_tile_scaled_accumulate_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // tile contents as seen by accepted requests
  logic signed [31:0] a_model [TileRowsDef][MaxDepthDef];
  logic signed [31:0] b_model [MaxDepthDef][TileColsDef];
  // entries already queued for writing, so a finish never reads garbage
  bit                 a_loaded [TileRowsDef][MaxDepthDef];
  bit                 b_loaded [MaxDepthDef][TileColsDef];

  logic signed [31:0] alpha_q = ALPHA_RST;
  logic signed [31:0] beta_q  = BETA_RST;
  logic [6:0]         depth_q = DEPTH_RST;

  tile_req_t request_q [$];
  c_result_t c_want_q [$];
  tile_req_t cur_req;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        phase_items = 0;
  int        fail_count = 0;

  function automatic logic signed [31:0] clip32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic c_result_t compute_c(input tile_req_t rq);
    c_result_t   res;
    longint      acc;
    longint      dot;
    longint      total;
    int unsigned n;
    int          d;
    n = (depth_q > MaxDepthDef) ? MaxDepthDef : depth_q;
    acc = 0;
    for (d = 0; d < n; d++) begin
      acc += (longint'(a_model[rq.row][d]) * longint'(b_model[d][rq.col])) >>> 16;
    end
    dot = clip32(acc);
    total = ((longint'(alpha_q) * dot) >>> 16)
          + ((longint'($signed(rq.value)) * longint'(beta_q)) >>> 16);
    res.value = clip32(total);
    res.row = rq.row;
    res.col = rq.col;
    return res;
  endfunction

  task automatic apply_request(input tile_req_t rq);
    case (rq.op)
      OP_LOAD_A: a_model[rq.row][rq.depth] = rq.value;
      OP_LOAD_B: b_model[rq.depth][rq.col] = rq.value;
      OP_FINISH: c_want_q.push_back(compute_c(rq));
      default: ;
    endcase
  endtask

  // driver: hold each request until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= OP_NONE;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) apply_request(cur_req);
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = request_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, cur_req.value, cur_req.depth, cur_req.col, cur_req.row};
        s_axis_tuser  <= cur_req.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    c_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (c_want_q.size() == 0) begin
          $error("C element with none pending: tdata %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = c_want_q.pop_front();
          if (m_axis_tdata[31:0] !== want.value) begin
            $error("out_value: expected %h, got %h", want.value, m_axis_tdata[31:0]);
            fail_count++;
          end
          if (m_axis_tdata[35:32] !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, m_axis_tdata[35:32]);
            fail_count++;
          end
          if (m_axis_tdata[39:36] !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, m_axis_tdata[39:36]);
            fail_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ALPHA: alpha_q = data;
      REG_BETA:  beta_q = data;
      REG_DEPTH: depth_q = data[6:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_scales(input logic [31:0] alpha, input logic [31:0] beta,
                            input logic [6:0] depth);
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_BETA, beta);
    write_reg(REG_DEPTH, {25'd0, depth});
  endtask

  function automatic logic [31:0] small_q16();
    return $urandom_range(32'h0008_0000) - 32'h0004_0000;
  endfunction

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: return small_q16();
      default: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
    endcase
  endfunction

  task automatic queue_req(input op_e op, input logic [3:0] row, input logic [3:0] col,
                           input logic [5:0] dep, input logic [31:0] val);
    tile_req_t rq;
    rq.op = op;
    rq.row = row;
    rq.col = col;
    rq.depth = dep;
    rq.value = val;
    request_q.push_back(rq);
    if (op == OP_LOAD_A) a_loaded[row][dep] = 1'b1;
    if (op == OP_LOAD_B) b_loaded[dep][col] = 1'b1;
    if (op != OP_NONE) phase_items++;
  endtask

  function automatic bit dot_ready(input logic [3:0] row, input logic [3:0] col,
                                   input int unsigned n);
    int d;
    for (d = 0; d < n; d++) begin
      if (!a_loaded[row][d] || !b_loaded[d][col]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // load one A row and one B column as far as needed, then finish on them
  task automatic queue_dot_sequence(input int unsigned n);
    logic [3:0] row;
    logic [3:0] col;
    int         d;
    row = 4'($urandom_range(15));
    col = 4'($urandom_range(15));
    for (d = 0; d < n; d++) begin
      if (!a_loaded[row][d] || $urandom_range(3) == 0)
        queue_req(OP_LOAD_A, row, 4'($urandom), 6'(d), rand_q16());
      if (!b_loaded[d][col] || $urandom_range(3) == 0)
        queue_req(OP_LOAD_B, 4'($urandom), col, 6'(d), rand_q16());
    end
    queue_req(OP_FINISH, row, col, 6'($urandom), rand_q16());
  endtask

  task automatic queue_any_finish(input int unsigned n);
    logic [3:0] row;
    logic [3:0] col;
    int         tries;
    for (tries = 0; tries < 8; tries++) begin
      row = 4'($urandom_range(15));
      col = 4'($urandom_range(15));
      if (dot_ready(row, col, n)) begin
        queue_req(OP_FINISH, row, col, 6'($urandom), rand_q16());
        return;
      end
    end
    queue_dot_sequence(n);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (request_q.size() != 0 || s_axis_tvalid || c_want_q.size() != 0);
    // let a trailing load or a finish in flight settle
    repeat (100) @(negedge clk_i);
  endtask

  task automatic run_traffic(input int s_idle, input int r_stall, input int count);
    int unsigned n;
    int          k;
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    n = (depth_q > MaxDepthDef) ? MaxDepthDef : depth_q;
    phase_items = 0;
    while (phase_items < count) begin
      k = $urandom_range(99);
      if (k < 8) begin
        queue_req(OP_NONE, 4'($urandom), 4'($urandom), 6'($urandom), $urandom);
      end else if (k < 18) begin
        queue_req($urandom_range(1) ? OP_LOAD_B : OP_LOAD_A,
                  4'($urandom), 4'($urandom), 6'($urandom), rand_q16());
      end else if (k < 45) begin
        queue_any_finish(n);
      end else begin
        queue_dot_sequence(n);
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: unit alpha, zero beta, full depth
    run_traffic(0, 0, 120);

    set_scales(32'h0001_0000, 32'h0001_0000, 7'd2);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_req(OP_LOAD_A, 4'd0, 4'd0, 6'd0, 32'h7FFF_FFFF);
    queue_req(OP_LOAD_A, 4'd0, 4'd15, 6'd1, 32'h7FFF_FFFF);
    queue_req(OP_LOAD_B, 4'd15, 4'd0, 6'd0, 32'h7FFF_FFFF);
    queue_req(OP_LOAD_B, 4'd0, 4'd0, 6'd1, 32'h7FFF_FFFF);
    // sum saturates high
    queue_req(OP_FINISH, 4'd0, 4'd0, 6'd63, 32'h7FFF_FFFF);
    queue_req(OP_LOAD_A, 4'd15, 4'd0, 6'd0, 32'h8000_0000);
    queue_req(OP_LOAD_A, 4'd15, 4'd0, 6'd1, 32'h8000_0000);
    queue_req(OP_LOAD_B, 4'd0, 4'd15, 6'd0, 32'h7FFF_FFFF);
    queue_req(OP_LOAD_B, 4'd0, 4'd15, 6'd1, 32'h7FFF_FFFF);
    // sum saturates low
    queue_req(OP_FINISH, 4'd15, 4'd15, 6'd0, 32'h8000_0000);
    queue_req(OP_FINISH, 4'd0, 4'd15, 6'd0, 32'hFFFF_FFFF);
    queue_req(OP_FINISH, 4'd15, 4'd0, 6'd0, 32'h0000_0000);
    // unused op code: drop silently
    queue_req(OP_NONE, 4'd15, 4'd15, 6'd63, 32'hFFFF_FFFF);
    queue_req(OP_LOAD_A, 4'd15, 4'd15, 6'd63, 32'hFFFF_FFFF);
    queue_req(OP_LOAD_B, 4'd15, 4'd15, 6'd63, 32'h0000_0001);
    queue_req(OP_LOAD_A, 4'd0, 4'd0, 6'd0, 32'h0000_0000);
    queue_req(OP_FINISH, 4'd0, 4'd0, 6'd0, 32'h0000_0001);
    wait_drained();

    // zero depth: only beta*c remains
    set_scales(32'h8000_0000, 32'h7FFF_FFFF, 7'd0);
    queue_req(OP_FINISH, 4'd3, 4'd7, 6'd0, 32'h8000_0000);
    queue_req(OP_FINISH, 4'd12, 4'd9, 6'd5, 32'h7FFF_FFFF);
    queue_req(OP_NONE, 4'd0, 4'd0, 6'd0, 32'h0000_0000);
    wait_drained();

    set_scales(32'h0001_0000, 32'h0000_8000, 7'd8);
    run_traffic(0, 0, 90);
    set_scales(small_q16(), small_q16(), 7'd1);
    run_traffic(79, 0, 100);
    set_scales(32'h7FFF_FFFF, 32'h8000_0000, 7'd4);
    run_traffic(0, 79, 100);
    set_scales(32'h8000_0000, 32'h7FFF_FFFF, 7'd16);
    run_traffic(15, 15, 100);
    set_scales(32'h0000_0000, small_q16(), 7'd3);
    run_traffic(0, 0, 80);
    set_scales(small_q16(), 32'h0000_0000, 7'd0);
    run_traffic(79, 0, 60);
    // depth beyond the tile: capped at full depth
    set_scales($urandom, $urandom, 7'd127);
    run_traffic(0, 79, 100);
    set_scales(small_q16(), small_q16(), 7'd64);
    run_traffic(15, 15, 100);
    set_scales(small_q16(), small_q16(), 7'($urandom_range(12, 1)));
    run_traffic(0, 0, 100);
    set_scales(small_q16(), small_q16(), 7'd100);
    run_traffic(79, 0, 50);
    set_scales($urandom, $urandom, 7'd6);
    run_traffic(0, 79, 80);
    set_scales(32'hFFFF_0000, small_q16(), 7'd2);
    run_traffic(15, 15, 80);

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
